FILE: design/mexp_pkg.sv
// Shared constants and control types for the modular exponentiation unit.
package mexp_pkg;

   localparam int BASE_WIDTH     = 64;
   localparam int CNT_WIDTH      = $clog2(BASE_WIDTH);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_MODULUS = 1'b0;
   localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

   typedef struct packed {
      logic load;
      logic red_step;
      logic red_fix;
      logic mul_start;
      logic mul_step;
      logic mul_commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic exp_zero;
   } status_type;

endpackage

FILE: design/mexp_req_if.sv
// Request channel interface: request type, signed base and exponent.
interface mexp_req_if
   import mexp_pkg::*;
#(
   parameter int EXP_WIDTH = 63
);
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic signed [BASE_WIDTH-1:0] base;
   logic [EXP_WIDTH-1:0]         exponent;

   modport source (output valid, req_type, base, exponent, input ready);
   modport sink (input valid, req_type, base, exponent, output ready);
endinterface

FILE: design/mexp_rsp_if.sv
// Response channel interface: the residue result.
interface mexp_rsp_if #(
   parameter int MOD_WIDTH = 31
);
   logic                 valid;
   logic                 ready;
   logic [MOD_WIDTH-1:0] result;

   modport source (output valid, result, input ready);
   modport sink (input valid, result, output ready);
endinterface

FILE: design/mexp_datapath.sv
// Datapath: base reduction divider, two serial modular multipliers and exponent register.
module mexp_datapath
   import mexp_pkg::*;
#(
   parameter int MOD_WIDTH = 31,
   parameter int EXP_WIDTH = 63
) (
   input  logic                         clock,
   input  logic [MOD_WIDTH-1:0]         modulus,
   input  logic                         req_type,
   input  logic signed [BASE_WIDTH-1:0] base,
   input  logic [EXP_WIDTH-1:0]         exponent,
   input  cmd_type                      cmd,
   output status_type                   stat,
   output logic [MOD_WIDTH-1:0]         result
);

   localparam int EW = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

   logic [MOD_WIDTH-1:0]  m_ff, rem_ff, a_ff, res_ff, acc_r_ff, acc_a_ff;
   logic [MOD_WIDTH-1:0]  rb_ff, ab_ff, result_ff;
   logic [BASE_WIDTH-1:0] mag_ff;
   logic                  neg_ff;
   logic [EW-1:0]         exp_ff;

   logic [MOD_WIDTH-1:0]  m_eff, inv_exp, rem_in;
   logic [MOD_WIDTH:0]    trial;

   // One step of interleaved modular multiplication: acc = 2*acc + bit*addend mod m.
   function automatic logic [MOD_WIDTH-1:0] horner_step(input logic [MOD_WIDTH-1:0] acc,
                                                         input logic [MOD_WIDTH-1:0] addend,
                                                         input logic [MOD_WIDTH-1:0] m,
                                                         input logic bit_in);
      logic [MOD_WIDTH:0]   dbl;
      logic [MOD_WIDTH:0]   sum;
      logic [MOD_WIDTH-1:0] red;
      dbl = {acc, 1'b0};
      red = (dbl >= {1'b0, m}) ? MOD_WIDTH'(dbl - {1'b0, m}) : MOD_WIDTH'(dbl);
      sum = {1'b0, red} + (bit_in ? {1'b0, addend} : '0);
      return (sum >= {1'b0, m}) ? MOD_WIDTH'(sum - {1'b0, m}) : MOD_WIDTH'(sum);
   endfunction

   // A zero modulus behaves as a modulus of one.
   assign m_eff   = (modulus == '0) ? MOD_WIDTH'(1) : modulus;
   assign inv_exp = (m_eff >= MOD_WIDTH'(3)) ? (m_eff - MOD_WIDTH'(2)) : '0;

   assign trial  = {rem_ff, mag_ff[BASE_WIDTH-1]};
   assign rem_in = (trial >= {1'b0, m_ff}) ? MOD_WIDTH'(trial - {1'b0, m_ff})
                                           : MOD_WIDTH'(trial);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         m_ff   <= m_eff;
         neg_ff <= base[BASE_WIDTH-1];
         mag_ff <= base[BASE_WIDTH-1] ? (~base + 1'b1) : base;
         rem_ff <= '0;
         res_ff <= MOD_WIDTH'(1);
         exp_ff <= req_type ? EW'(inv_exp) : EW'(exponent);
      end
      if (cmd.red_step) begin
         rem_ff <= rem_in;
         mag_ff <= {mag_ff[BASE_WIDTH-2:0], 1'b0};
      end
      if (cmd.red_fix) begin
         a_ff <= (neg_ff && rem_ff != '0) ? (m_ff - rem_ff) : rem_ff;
      end
      if (cmd.mul_start) begin
         acc_r_ff <= '0;
         acc_a_ff <= '0;
         rb_ff    <= res_ff;
         ab_ff    <= a_ff;
      end
      if (cmd.mul_step) begin
         acc_r_ff <= horner_step(acc_r_ff, a_ff, m_ff, rb_ff[MOD_WIDTH-1]);
         acc_a_ff <= horner_step(acc_a_ff, a_ff, m_ff, ab_ff[MOD_WIDTH-1]);
         rb_ff    <= {rb_ff[MOD_WIDTH-2:0], 1'b0};
         ab_ff    <= {ab_ff[MOD_WIDTH-2:0], 1'b0};
      end
      if (cmd.mul_commit) begin
         if (exp_ff[0]) begin
            res_ff <= acc_r_ff;
         end
         a_ff   <= acc_a_ff;
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.out_load) begin
         result_ff <= res_ff;
      end
   end

   assign stat.exp_zero = (exp_ff == '0);
   assign result        = result_ff;

endmodule

FILE: design/mexp_controller.sv
// Controller: sequences reduction, multiply rounds and result hand-over.
module mexp_controller
   import mexp_pkg::*;
#(
   parameter int MOD_WIDTH = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type stat
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_FIX    = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_MULT   = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_WIDTH'(BASE_WIDTH - 1);
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.red_fix = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.exp_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cnt_in        = CNT_WIDTH'(MOD_WIDTH - 1);
               state_in      = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.mul_commit = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: design/modular_exponentiation_unit.sv
// Top level: modulus register, controller and datapath of the modular exponentiation unit.
//
//   Channel   Direction  Handshake          Payload
//   req_ch    in         valid/ready        req_type, base, exponent
//   rsp_ch    out        valid/ready        result
//   csr_*     in/out     APB, pready high   modulus at byte address 0
//
// A request is taken only when the unit is idle. It then reduces the base one quotient bit a
// cycle and fixes up the sign of the residue. For each significant exponent bit it runs a check,
// a round of the bit-serial modular multipliers and a commit; a final check and the hand-over of
// the result end the request.
// The result register lets the next request start while the previous response waits.
// Reset is synchronous and restores the modulus to 1000000007; a stalled response holds.
module modular_exponentiation_unit
   import mexp_pkg::*;
#(
   parameter int MOD_WIDTH = 31,
   parameter int EXP_WIDTH = 63
) (
   input  logic                      clock,
   input  logic                      reset,
   mexp_req_if.sink                  req_ch,
   mexp_rsp_if.source                rsp_ch,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [MOD_WIDTH-1:0]     modulus_ff, modulus_in;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic                     csr_write;
   cmd_type                  cmd;
   status_type               stat;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign modulus_in = (csr_write && csr_index == REG_MODULUS)
                       ? csr_pwdata[MOD_WIDTH-1:0] : modulus_ff;
   assign csr_prdata = (csr_index == REG_MODULUS) ? CSR_DATA_WIDTH'(modulus_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET[MOD_WIDTH-1:0];
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   mexp_controller #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mexp_datapath #(
      .MOD_WIDTH (MOD_WIDTH),
      .EXP_WIDTH (EXP_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .modulus  (modulus_ff),
      .req_type (req_ch.req_type),
      .base     (req_ch.base),
      .exponent (req_ch.exponent),
      .cmd      (cmd),
      .stat     (stat),
      .result   (rsp_ch.result)
   );

endmodule
